// ----- rtl/epau_pkg.sv -----
package epau_pkg;

  localparam int FRAC_BITS = 16;
  localparam int VAL_W     = 32;
  localparam int ERR_W     = 31;
  localparam int DIV_W     = 64;
  localparam int NUM_CELLS = 32;

  localparam logic signed [63:0] VMAX64 = 64'sd2147483647;
  localparam logic signed [63:0] VMIN64 = -64'sd2147483648;
  localparam logic [63:0]        EMAX64 = 64'h7FFF_FFFF;

  typedef enum logic [3:0] {
    CMD_ADD = 4'd0,
    CMD_SUB = 4'd1,
    CMD_MUL = 4'd2,
    CMD_DIV = 4'd3,
    CMD_LT  = 4'd4,
    CMD_EQ  = 4'd5,
    CMD_GT  = 4'd6,
    CMD_GE  = 4'd7,
    CMD_LE  = 4'd8,
    CMD_NE  = 4'd9,
    CMD_NEG = 4'd10
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIVZ = 2'd2
  } status_t;

  typedef struct packed {
    logic [DIV_W-1:0]     rem;
    logic [DIV_W-1:0]     den;
    logic [NUM_CELLS-1:0] bits;
    logic [NUM_CELLS-1:0] quo;
  } lane_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [ERR_W-1:0] error;
    logic             flag;
    logic [1:0]       status;
    logic             is_div;
    logic             neg;
    logic             bzero;
    logic             ovf_q;
    logic             ovf_e;
  } side_t;

  typedef struct packed {
    logic            valid;
    side_t           side;
    lane_t [2:0]     lane;
  } stage_t;

endpackage

// ----- rtl/epau_div_cell.sv -----
module epau_div_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  epau_pkg::stage_t    d_in,
  output epau_pkg::stage_t    d_out
);

  epau_pkg::stage_t stg_r;
  epau_pkg::stage_t stg_nxt;

  always_comb begin
    logic [epau_pkg::DIV_W-1:0] r;
    logic                       ge;
    stg_nxt = d_in;
    for (int i = 0; i < 3; i++) begin
      r  = {d_in.lane[i].rem[epau_pkg::DIV_W-2:0], d_in.lane[i].bits[epau_pkg::NUM_CELLS-1]};
      ge = (r >= d_in.lane[i].den);
      stg_nxt.lane[i].rem  = ge ? (r - d_in.lane[i].den) : r;
      stg_nxt.lane[i].bits = {d_in.lane[i].bits[epau_pkg::NUM_CELLS-2:0], 1'b0};
      stg_nxt.lane[i].quo  = {d_in.lane[i].quo[epau_pkg::NUM_CELLS-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r.valid <= 1'b0;
    end else if (adv) begin
      stg_r.valid <= stg_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stg_r.side <= stg_nxt.side;
      stg_r.lane <= stg_nxt.lane;
    end
  end

  assign d_out = stg_r;

endmodule

// ----- rtl/epau_front.sv -----
module epau_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic                    in_valid,
  input  logic [3:0]              in_command,
  input  logic signed [31:0]      in_first_value,
  input  logic [30:0]             in_first_error,
  input  logic signed [31:0]      in_second_value,
  input  logic [30:0]             in_second_error,
  output epau_pkg::stage_t        cell_in
);

  logic                 a_valid_r;
  epau_pkg::cmd_t       a_cmd_r;
  epau_pkg::side_t      a_side_r;
  epau_pkg::side_t      a_side_nxt;
  logic signed [63:0]   a_p_r;
  logic [63:0]          a_pe1_r;
  logic [63:0]          a_pe2_r;
  logic [63:0]          a_bsq_r;
  logic [31:0]          a_ma_r;
  logic [31:0]          a_mb_r;
  logic [30:0]          a_ea_r;
  logic [31:0]          ma;
  logic [31:0]          mb;
  epau_pkg::stage_t     b_r;
  epau_pkg::stage_t     b_nxt;

  assign ma = in_first_value[31]  ? (~in_first_value + 32'd1)  : in_first_value;
  assign mb = in_second_value[31] ? (~in_second_value + 32'd1) : in_second_value;

  always_comb begin
    logic signed [33:0] av;
    logic signed [33:0] bv;
    logic signed [33:0] ea;
    logic signed [33:0] eb;
    logic signed [33:0] rv;
    logic [31:0]        es;
    logic               lt;
    logic               eq;
    logic               gt;
    av = {{2{in_first_value[31]}}, in_first_value};
    bv = {{2{in_second_value[31]}}, in_second_value};
    ea = {3'b000, in_first_error};
    eb = {3'b000, in_second_error};
    lt = (av + ea) < (bv - eb);
    gt = (av - ea) > (bv + eb);
    eq = ((av - ea) <= (bv + eb)) && ((bv - eb) <= (av + ea));
    es = {1'b0, in_first_error} + {1'b0, in_second_error};
    rv = '0;
    a_side_nxt = '0;
    a_side_nxt.status = epau_pkg::ST_OK;
    a_side_nxt.is_div = (in_command == epau_pkg::CMD_DIV);
    a_side_nxt.neg    = in_first_value[31] ^ in_second_value[31];
    a_side_nxt.bzero  = (in_second_value == 32'sd0);
    case (in_command) inside
      epau_pkg::CMD_ADD, epau_pkg::CMD_SUB, epau_pkg::CMD_NEG: begin
        if (in_command == epau_pkg::CMD_ADD) begin
          rv = av + bv;
        end else if (in_command == epau_pkg::CMD_SUB) begin
          rv = av - bv;
        end else begin
          rv = -av;
        end
        if (in_command == epau_pkg::CMD_NEG) begin
          a_side_nxt.error = in_first_error;
        end else if (es[31]) begin
          a_side_nxt.error  = '1;
          a_side_nxt.status = epau_pkg::ST_SAT;
        end else begin
          a_side_nxt.error = es[30:0];
        end
        if (rv > 34'sd2147483647) begin
          a_side_nxt.value  = 32'h7FFF_FFFF;
          a_side_nxt.status = epau_pkg::ST_SAT;
        end else if (rv < -34'sd2147483648) begin
          a_side_nxt.value  = 32'h8000_0000;
          a_side_nxt.status = epau_pkg::ST_SAT;
        end else begin
          a_side_nxt.value = rv[31:0];
        end
      end
      epau_pkg::CMD_LT: a_side_nxt.flag = lt;
      epau_pkg::CMD_EQ: a_side_nxt.flag = eq;
      epau_pkg::CMD_GT: a_side_nxt.flag = gt;
      epau_pkg::CMD_GE: a_side_nxt.flag = gt | eq;
      epau_pkg::CMD_LE: a_side_nxt.flag = lt | eq;
      epau_pkg::CMD_NE: a_side_nxt.flag = ~eq;
      default: a_side_nxt.flag = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_cmd_r  <= epau_pkg::cmd_t'(in_command);
      a_side_r <= a_side_nxt;
      a_p_r    <= 64'(in_first_value) * 64'(in_second_value);
      a_pe1_r  <= 64'(in_first_error) * 64'(mb);
      a_pe2_r  <= 64'(ma) * 64'(in_second_error);
      a_bsq_r  <= 64'(mb) * 64'(mb);
      a_ma_r   <= ma;
      a_mb_r   <= mb;
      a_ea_r   <= in_first_error;
    end
  end

  always_comb begin
    logic signed [63:0] pr;
    logic signed [63:0] mv;
    logic [63:0]        se;
    logic [63:0]        me;
    logic [95:0]        x0;
    logic [95:0]        x1;
    logic [95:0]        x2;
    pr = a_p_r + 64'sd1 * ((64'sd1 <<< epau_pkg::FRAC_BITS) >>> 1);
    mv = pr >>> epau_pkg::FRAC_BITS;
    se = a_pe1_r + a_pe2_r + ((64'd1 << epau_pkg::FRAC_BITS) - 64'd1);
    me = se >> epau_pkg::FRAC_BITS;
    x0 = 96'(a_ma_r) << epau_pkg::FRAC_BITS;
    x1 = 96'(a_ea_r) << epau_pkg::FRAC_BITS;
    x2 = 96'(a_pe2_r) << epau_pkg::FRAC_BITS;
    b_nxt.valid = a_valid_r;
    b_nxt.side  = a_side_r;
    b_nxt.lane[0].rem  = x0[95:32];
    b_nxt.lane[0].bits = x0[31:0];
    b_nxt.lane[0].den  = 64'(a_mb_r);
    b_nxt.lane[0].quo  = '0;
    b_nxt.lane[1].rem  = x1[95:32];
    b_nxt.lane[1].bits = x1[31:0];
    b_nxt.lane[1].den  = 64'(a_mb_r);
    b_nxt.lane[1].quo  = '0;
    b_nxt.lane[2].rem  = x2[95:32];
    b_nxt.lane[2].bits = x2[31:0];
    b_nxt.lane[2].den  = a_bsq_r;
    b_nxt.lane[2].quo  = '0;
    b_nxt.side.ovf_q = (x0[95:32] >= 64'(a_mb_r));
    b_nxt.side.ovf_e = (x1[95:32] >= 64'(a_mb_r)) || (x2[95:32] >= a_bsq_r);
    if (a_cmd_r == epau_pkg::CMD_MUL) begin
      b_nxt.side.status = epau_pkg::ST_OK;
      if (mv > epau_pkg::VMAX64) begin
        b_nxt.side.value  = 32'h7FFF_FFFF;
        b_nxt.side.status = epau_pkg::ST_SAT;
      end else if (mv < epau_pkg::VMIN64) begin
        b_nxt.side.value  = 32'h8000_0000;
        b_nxt.side.status = epau_pkg::ST_SAT;
      end else begin
        b_nxt.side.value = mv[31:0];
      end
      if (me > epau_pkg::EMAX64) begin
        b_nxt.side.error  = '1;
        b_nxt.side.status = epau_pkg::ST_SAT;
      end else begin
        b_nxt.side.error = me[30:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_r.valid <= 1'b0;
    end else if (adv) begin
      b_r.valid <= b_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_r.side <= b_nxt.side;
      b_r.lane <= b_nxt.lane;
    end
  end

  assign cell_in = b_r;

endmodule

// ----- rtl/error_propagating_arithmetic_unit.sv -----
// Error-propagating arithmetic unit on signed Q16.16 values with absolute error bounds.
// Input channel: in_valid/in_ready carry a command and two value/error operand pairs.
// Output channel: out_valid/out_ready carry result value, error bound, compare flag
// and status (ok, saturated, divide by zero).
// Every transaction, whatever its command, flows through the same pipeline: two
// front stages (operand magnitudes and four 32x32 multipliers, then rounding and
// divider setup), a chain of 32 divider cells that each resolve one quotient bit of
// three divisions in parallel, and the output register.
// One transaction per cycle is accepted when the receiver keeps up.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// in_ready falls in the same cycle; it rises again as soon as the result is taken.
// Reset clears all valid bits, so the block comes out of reset empty and ready.
module error_propagating_arithmetic_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         in_command,
  input  logic signed [31:0] in_first_value,
  input  logic [30:0]        in_first_error,
  input  logic signed [31:0] in_second_value,
  input  logic [30:0]        in_second_error,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_result_value,
  output logic [30:0]        out_result_error,
  output logic               out_compare_flag,
  output logic [1:0]         out_status
);

  logic                 adv;
  epau_pkg::stage_t     chain [epau_pkg::NUM_CELLS+1];
  epau_pkg::stage_t     last;
  logic                 out_valid_r;
  logic [31:0]          out_value_r;
  logic [31:0]          out_value_nxt;
  logic [30:0]          out_error_r;
  logic [30:0]          out_error_nxt;
  logic                 out_flag_r;
  logic [1:0]           out_status_r;
  logic [1:0]           out_status_nxt;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  epau_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .adv             (adv),
    .in_valid        (in_valid),
    .in_command      (in_command),
    .in_first_value  (in_first_value),
    .in_first_error  (in_first_error),
    .in_second_value (in_second_value),
    .in_second_error (in_second_error),
    .cell_in         (chain[0])
  );

  for (genvar g = 0; g < epau_pkg::NUM_CELLS; g++) begin : g_cell
    epau_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .d_in  (chain[g]),
      .d_out (chain[g+1])
    );
  end

  assign last = chain[epau_pkg::NUM_CELLS];

  always_comb begin
    logic [31:0] q0;
    logic [33:0] e1;
    logic [33:0] e2;
    logic [33:0] es;
    q0 = last.lane[0].quo;
    e1 = 34'(last.lane[1].quo) + 34'(last.lane[1].rem != '0);
    e2 = 34'(last.lane[2].quo) + 34'(last.lane[2].rem != '0);
    es = e1 + e2;
    out_value_nxt  = last.side.value;
    out_error_nxt  = last.side.error;
    out_status_nxt = last.side.status;
    if (last.side.is_div) begin
      out_status_nxt = epau_pkg::ST_OK;
      if (last.side.bzero) begin
        out_value_nxt  = '0;
        out_error_nxt  = '0;
        out_status_nxt = epau_pkg::ST_DIVZ;
      end else begin
        if (last.side.neg) begin
          if (last.side.ovf_q || q0 > 32'h8000_0000) begin
            out_value_nxt  = 32'h8000_0000;
            out_status_nxt = epau_pkg::ST_SAT;
          end else begin
            out_value_nxt = 32'd0 - q0;
          end
        end else begin
          if (last.side.ovf_q || q0[31]) begin
            out_value_nxt  = 32'h7FFF_FFFF;
            out_status_nxt = epau_pkg::ST_SAT;
          end else begin
            out_value_nxt = q0;
          end
        end
        if (last.side.ovf_e || es > 34'h7FFF_FFFF) begin
          out_error_nxt  = '1;
          out_status_nxt = epau_pkg::ST_SAT;
        end else begin
          out_error_nxt = es[30:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_value_r  <= out_value_nxt;
      out_error_r  <= out_error_nxt;
      out_flag_r   <= last.side.flag;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_result_error = out_error_r;
  assign out_compare_flag = out_flag_r;
  assign out_status       = out_status_r;

`ifndef ASSERT_OFF
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status != 2'd3))
    else $error("Reserved status code on a result transaction.");

  a_flag_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_compare_flag) |-> (out_result_value == '0 && out_result_error == '0
      && out_status == epau_pkg::ST_OK))
    else $error("Comparison result carries arithmetic fields.");

  a_divz_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == epau_pkg::ST_DIVZ) |-> (out_result_value == '0
      && out_result_error == '0))
    else $error("Divide by zero result is not cleared.");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_result_value)
      && $stable(out_status)))
    else $error("Stalled result transaction changed.");
`endif

endmodule
